/* hw/rtl/eeprom_shadow_cache_with_retry_macros.svh */
// Assertion helpers for the EEPROM shadow cache.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef EEPROM_SHADOW_CACHE_WITH_RETRY_MACROS_SVH
`define EEPROM_SHADOW_CACHE_WITH_RETRY_MACROS_SVH

`ifndef SYNTHESIS

`define ESC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ESC_ASSERT(lbl, cond, msg)

`define ESC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hw/rtl/esc_pkg.sv */
`default_nettype none

package esc_pkg;

  localparam int unsigned ADDR_W = 9;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // request types
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_RESP  = 2'd2;

  // completion status
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_RANGE      = 3'd1;
  localparam logic [2:0] ST_BUSFAIL    = 3'd2;
  localparam logic [2:0] ST_BUSY       = 3'd3;
  localparam logic [2:0] ST_UNEXPECTED = 3'd4;

  // result kinds
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_BUS  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE      = 1'b1;

  localparam logic [7:0] RETRY_LIMIT_RST = 8'd200;
  localparam logic [7:0] DEVICE_RST      = 8'd160;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/eeprom_shadow_cache_with_retry.sv */
// Write-through shadow cache for a serial EEPROM with bus retry. Every accepted beat on the
// input channel (read, write or bus response) yields exactly one result beat, except request
// type 3, which is dropped. Each beat goes first through the synchronous read of the
// cache memory entry ({valid, byte}), then through the decision, write back and load of the
// output register, which waits while the output register is full and stalled; the next beat
// is taken once the result is in the output register. After reset the block sweeps all
// min(CACHE_SIZE, 512) cache memory entries to clear every valid bit, one entry a cycle, and
// holds in_stall high meanwhile; cfg writes are taken at any time. A bus request on the output
// must be answered by a response beat; requests that arrive meanwhile complete as busy.
`default_nettype none

`include "eeprom_shadow_cache_with_retry_macros.svh"

module eeprom_shadow_cache_with_retry #(
  parameter int unsigned CACHE_SIZE = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           cfg_we,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]                     cfg_wdata,

  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [1:0]                     in_req_type,
  input  wire logic [esc_pkg::ADDR_W-1:0]     in_address,
  input  wire logic [7:0]                     in_write_data,
  input  wire logic                           in_bus_ok,
  input  wire logic [7:0]                     in_bus_read_data,
  input  wire logic [3:0]                     in_bus_error_code,

  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic                           out_result_kind,
  output      logic [2:0]                     out_status,
  output      logic [7:0]                     out_read_data,
  output      logic [3:0]                     out_error_code,
  output      logic                           out_bus_is_write,
  output      logic [7:0]                     out_bus_device,
  output      logic [7:0]                     out_bus_mem_address,
  output      logic [7:0]                     out_bus_write_data
);

  // Only addresses the 9-bit field can reach need storage.
  localparam int unsigned ADDR_SPAN = 1 << esc_pkg::ADDR_W;
  localparam int unsigned DEPTH = (CACHE_SIZE < ADDR_SPAN) ? CACHE_SIZE : ADDR_SPAN;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [31:0] SIZE_LIM = 32'(CACHE_SIZE);

  esc_pkg::state_t state_r, state_nxt;

  logic [7:0] retry_limit_r;
  logic [7:0] device_r;

  // cache memory: bit 8 valid, bits 7:0 data
  logic [8:0]       mem [DEPTH];
  logic [8:0]       rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [8:0]       mem_wdata;
  logic             in_accept;

  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;

  // captured beat
  logic [1:0]                  req_type_r;
  logic [esc_pkg::ADDR_W-1:0]  req_addr_r;
  logic [7:0]                  req_wdata_r;
  logic                        req_ok_r;
  logic [7:0]                  req_rdata_r;
  logic [3:0]                  req_ecode_r;

  // outstanding bus transfer
  logic             pend_r, pend_nxt;
  logic             pend_wr_r, pend_wr_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [7:0]       pend_byte_r, pend_byte_nxt;
  logic [7:0]       retries_r, retries_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic       out_load;
  logic       out_free;
  logic       kind_nxt;
  logic [2:0] status_nxt;
  logic [7:0] rdata_nxt;
  logic [3:0] ecode_nxt;
  logic       bwr_nxt;
  logic [7:0] bdev_nxt;
  logic [7:0] baddr_nxt;
  logic [7:0] bdata_nxt;

  logic       in_range;
  logic       hit;

  assign in_stall  = (state_r != esc_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  assign in_range = ({{(32 - esc_pkg::ADDR_W){1'b0}}, req_addr_r} < SIZE_LIM);
  assign hit      = rd_q[8];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= esc_pkg::RETRY_LIMIT_RST;
      device_r      <= esc_pkg::DEVICE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        esc_pkg::CFG_RETRY_LIMIT: retry_limit_r <= cfg_wdata;
        esc_pkg::CFG_DEVICE:      device_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // cache memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_q <= mem[in_address[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_type_r  <= in_req_type;
      req_addr_r  <= in_address;
      req_wdata_r <= in_write_data;
      req_ok_r    <= in_bus_ok;
      req_rdata_r <= in_bus_read_data;
      req_ecode_r <= in_bus_error_code;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_idx_r;
    mem_wdata     = 9'd0;
    pend_nxt      = pend_r;
    pend_wr_nxt   = pend_wr_r;
    pend_addr_nxt = pend_addr_r;
    pend_byte_nxt = pend_byte_r;
    retries_nxt   = retries_r;
    out_load      = 1'b0;
    kind_nxt      = esc_pkg::KIND_DONE;
    status_nxt    = esc_pkg::ST_OK;
    rdata_nxt     = 8'd0;
    ecode_nxt     = 4'd0;
    bwr_nxt       = 1'b0;
    bdev_nxt      = 8'd0;
    baddr_nxt     = 8'd0;
    bdata_nxt     = 8'd0;

    case (state_r)
      esc_pkg::S_CLEAR: begin
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = esc_pkg::S_IDLE;
        end
      end
      esc_pkg::S_IDLE: begin
        if (in_accept) begin
          state_nxt = esc_pkg::S_LOOK;
        end
      end
      esc_pkg::S_LOOK: begin
        // hold until the output register can take the result
        if (out_free) begin
          state_nxt = esc_pkg::S_IDLE;
          case (req_type_r)
            esc_pkg::REQ_READ, esc_pkg::REQ_WRITE: begin
              out_load = 1'b1;
              if (pend_r) begin
                status_nxt = esc_pkg::ST_BUSY;
              end else if (!in_range) begin
                status_nxt = esc_pkg::ST_RANGE;
              end else if (req_type_r == esc_pkg::REQ_READ && hit) begin
                rdata_nxt = rd_q[7:0];
              end else if (req_type_r == esc_pkg::REQ_WRITE && hit &&
                           rd_q[7:0] == req_wdata_r) begin
                status_nxt = esc_pkg::ST_OK;
              end else begin
                pend_nxt      = 1'b1;
                pend_wr_nxt   = (req_type_r == esc_pkg::REQ_WRITE);
                pend_addr_nxt = req_addr_r[IDX_W-1:0];
                pend_byte_nxt = (req_type_r == esc_pkg::REQ_WRITE) ? req_wdata_r : 8'd0;
                retries_nxt   = 8'd0;
                kind_nxt      = esc_pkg::KIND_BUS;
              end
            end
            esc_pkg::REQ_RESP: begin
              out_load = 1'b1;
              if (!pend_r) begin
                status_nxt = esc_pkg::ST_UNEXPECTED;
              end else if (req_ok_r) begin
                // fill the entry and mark it valid
                mem_we    = 1'b1;
                mem_waddr = pend_addr_r;
                mem_wdata = {1'b1, pend_wr_r ? pend_byte_r : req_rdata_r};
                pend_nxt  = 1'b0;
                rdata_nxt = pend_wr_r ? 8'd0 : req_rdata_r;
              end else if (retries_r < retry_limit_r) begin
                retries_nxt = 8'(retries_r + 8'd1);
                kind_nxt    = esc_pkg::KIND_BUS;
              end else begin
                pend_nxt   = 1'b0;
                status_nxt = esc_pkg::ST_BUSFAIL;
                ecode_nxt  = req_ecode_r;
              end
            end
            default: ;  // unused request type: drop
          endcase

          if (kind_nxt == esc_pkg::KIND_BUS) begin
            bwr_nxt   = pend_wr_nxt;
            bdev_nxt  = device_r;
            baddr_nxt = 8'(pend_addr_nxt);
            bdata_nxt = pend_wr_nxt ? pend_byte_nxt : 8'd0;
          end
        end
      end
      default: state_nxt = esc_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= esc_pkg::S_CLEAR;
      clr_idx_r   <= '0;
      pend_r      <= 1'b0;
      retries_r   <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      pend_r      <= pend_nxt;
      retries_r   <= retries_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_wr_r   <= pend_wr_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_byte_r <= pend_byte_nxt;
    if (out_load) begin
      out_result_kind     <= kind_nxt;
      out_status          <= status_nxt;
      out_read_data       <= rdata_nxt;
      out_error_code      <= ecode_nxt;
      out_bus_is_write    <= bwr_nxt;
      out_bus_device      <= bdev_nxt;
      out_bus_mem_address <= baddr_nxt;
      out_bus_write_data  <= bdata_nxt;
    end
  end

  `ESC_ASSERT(a_no_rd_wr_clash, !(mem_we && in_accept), "memory write during lookup read")
  `ESC_ASSERT(a_load_from_look, !out_load || state_r == esc_pkg::S_LOOK, "result outside lookup")
  `ESC_ASSERT_NEXT(a_accept_looks, in_accept, state_r == esc_pkg::S_LOOK, "accept without lookup")
  `ESC_ASSERT_NEXT(a_bus_req_pending, out_load && kind_nxt == esc_pkg::KIND_BUS, pend_r,
    "bus request without pending transfer")

endmodule

`default_nettype wire

/* sim/tb_eeprom_shadow_cache_with_retry.sv */
module tb_eeprom_shadow_cache_with_retry;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CACHE_DEPTH  = 256;
  localparam int unsigned PHASE_ITEMS  = 65;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] addr;
    logic [7:0] wdata;
    logic       ok;
    logic [7:0] rdata;
    logic [3:0] ecode;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] rdata;
    logic [3:0] ecode;
    logic       bus_write;
    logic [7:0] device;
    logic [7:0] mem_addr;
    logic [7:0] bus_wdata;
  } reply_t;

  class shadow_cache_scoreboard;
    logic [7:0] cached [CACHE_DEPTH];
    bit         valid_map [CACHE_DEPTH];
    bit         busy;
    bit         busy_write;
    logic [7:0] busy_addr;
    logic [7:0] busy_byte;
    logic [7:0] retries;
    logic [7:0] retry_cap;
    logic [7:0] device;
    reply_t     replies_due [$];
    int         mismatches;

    function new();
      foreach (cached[i]) begin
        cached[i] = '0;
        valid_map[i] = 1'b0;
      end
      busy = 1'b0;
      busy_write = 1'b0;
      busy_addr = '0;
      busy_byte = '0;
      retries = '0;
      retry_cap = esc_pkg::RETRY_LIMIT_RST;
      device = esc_pkg::DEVICE_RST;
      mismatches = 0;
    endfunction

    function reply_t bus_request_beat();
      reply_t y;
      y = '0;
      y.kind = esc_pkg::KIND_BUS;
      y.bus_write = busy_write;
      y.device = device;
      y.mem_addr = busy_addr;
      y.bus_wdata = busy_write ? busy_byte : 8'h00;
      return y;
    endfunction

    function void note_request(req_t r);
      reply_t     y;
      logic [7:0] a;
      logic [7:0] b;
      y = '0;
      y.kind = esc_pkg::KIND_DONE;
      y.status = esc_pkg::ST_OK;
      a = r.addr[7:0];
      case (r.kind)
        esc_pkg::REQ_READ, esc_pkg::REQ_WRITE: begin
          if (busy) begin
            y.status = esc_pkg::ST_BUSY;
          end else if (r.addr >= CACHE_DEPTH) begin
            y.status = esc_pkg::ST_RANGE;
          end else if (r.kind == esc_pkg::REQ_READ && valid_map[a]) begin
            y.rdata = cached[a];
          end else if (r.kind == esc_pkg::REQ_WRITE && valid_map[a] &&
                       cached[a] == r.wdata) begin
            // equal value already cached: nothing to send
          end else begin
            busy = 1'b1;
            busy_write = (r.kind == esc_pkg::REQ_WRITE);
            busy_addr = a;
            busy_byte = busy_write ? r.wdata : 8'h00;
            retries = '0;
            y = bus_request_beat();
          end
        end
        esc_pkg::REQ_RESP: begin
          if (!busy) begin
            y.status = esc_pkg::ST_UNEXPECTED;
          end else if (r.ok) begin
            b = busy_write ? busy_byte : r.rdata;
            cached[busy_addr] = b;
            valid_map[busy_addr] = 1'b1;
            busy = 1'b0;
            y.rdata = busy_write ? 8'h00 : b;
          end else if (retries < retry_cap) begin
            retries = retries + 8'd1;
            y = bus_request_beat();
          end else begin
            busy = 1'b0;
            y.status = esc_pkg::ST_BUSFAIL;
            y.ecode = r.ecode;
          end
        end
        default: return;  // unused request type: dropped, no reply
      endcase
      replies_due.push_back(y);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        $error("reply beat with no request outstanding");
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      compare_field("result_kind", 8'(want.kind), 8'(got.kind));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("read_data", want.rdata, got.rdata);
      compare_field("error_code", 8'(want.ecode), 8'(got.ecode));
      compare_field("bus_is_write", 8'(want.bus_write), 8'(got.bus_write));
      compare_field("bus_device", want.device, got.device);
      compare_field("bus_mem_address", want.mem_addr, got.mem_addr);
      compare_field("bus_write_data", want.bus_wdata, got.bus_wdata);
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [esc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    in_req_type;
  logic [esc_pkg::ADDR_W-1:0]    in_address;
  logic [7:0]                    in_write_data;
  logic                          in_bus_ok;
  logic [7:0]                    in_bus_read_data;
  logic [3:0]                    in_bus_error_code;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_result_kind;
  logic [2:0]                    out_status;
  logic [7:0]                    out_read_data;
  logic [3:0]                    out_error_code;
  logic                          out_bus_is_write;
  logic [7:0]                    out_bus_device;
  logic [7:0]                    out_bus_mem_address;
  logic [7:0]                    out_bus_write_data;

  shadow_cache_scoreboard sb = new();
  int unsigned            cycles = 0;
  int                     calm_left = 0;

  eeprom_shadow_cache_with_retry #(
    .CACHE_SIZE(CACHE_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_address         (in_address),
    .in_write_data      (in_write_data),
    .in_bus_ok          (in_bus_ok),
    .in_bus_read_data   (in_bus_read_data),
    .in_bus_error_code  (in_bus_error_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_status         (out_status),
    .out_read_data      (out_read_data),
    .out_error_code     (out_error_code),
    .out_bus_is_write   (out_bus_is_write),
    .out_bus_device     (out_bus_device),
    .out_bus_mem_address(out_bus_mem_address),
    .out_bus_write_data (out_bus_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : watch_replies
    reply_t seen;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen = {out_result_kind, out_status, out_read_data, out_error_code,
              out_bus_is_write, out_bus_device, out_bus_mem_address, out_bus_write_data};
      sb.check_reply(seen);
    end
  end

  // receiver back-pressure: free runs mixed with short and occasional long stalls
  initial begin : stall_reply_side
    int run;
    int hold;
    int pick;
    out_stall = 1'b0;
    forever begin
      pick = $urandom_range(0, 99);
      run = (pick < 70) ? $urandom_range(1, 8) : $urandom_range(20, 60);
      repeat (run) @(posedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 75) hold = $urandom_range(1, 3);
      else if (pick < 95) hold = $urandom_range(4, 10);
      else hold = $urandom_range(15, 40);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  function automatic int gap_len();
    int pick;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) calm_left = $urandom_range(10, 40);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic req_t mk(logic [1:0] kind, logic [8:0] addr, logic [7:0] wdata,
                              logic ok, logic [7:0] rdata, logic [3:0] ecode);
    req_t r;
    r.kind = kind;
    r.addr = addr;
    r.wdata = wdata;
    r.ok = ok;
    r.rdata = rdata;
    r.ecode = ecode;
    return r;
  endfunction

  // mostly well-formed request/response exchanges over a small hot window
  function automatic req_t random_request(int fail_pct);
    req_t r;
    int   pick;
    int   where;
    r = mk(2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
           1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
    pick = $urandom_range(0, 99);
    if (sb.busy) begin
      if (pick < 85) begin
        r.kind = esc_pkg::REQ_RESP;
        r.ok = ($urandom_range(0, 99) >= fail_pct);
      end else if (pick < 97) begin
        r.kind = pick[0] ? esc_pkg::REQ_WRITE : esc_pkg::REQ_READ;
      end else begin
        r.kind = REQ_UNUSED;
      end
    end else if (pick < 88) begin
      r.kind = pick[0] ? esc_pkg::REQ_WRITE : esc_pkg::REQ_READ;
      where = $urandom_range(0, 99);
      if (where < 70) r.addr = 9'($urandom_range(0, 15));
      else if (where < 90) r.addr = 9'($urandom_range(0, CACHE_DEPTH - 1));
      else r.addr = 9'($urandom_range(CACHE_DEPTH, 511));
      if (r.kind == esc_pkg::REQ_WRITE && r.addr < CACHE_DEPTH && sb.valid_map[r.addr[7:0]]
          && $urandom_range(0, 99) < 40) begin
        r.wdata = sb.cached[r.addr[7:0]];
      end
    end else if (pick < 94) begin
      r.kind = esc_pkg::REQ_RESP;
    end else begin
      r.kind = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic send_beat(input req_t r);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.kind;
    in_address <= r.addr;
    in_write_data <= r.wdata;
    in_bus_ok <= r.ok;
    in_bus_read_data <= r.rdata;
    in_bus_error_code <= r.ecode;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_request(r);
  endtask

  // close any open transfer, then wait out every reply and the pipeline
  task automatic settle();
    while (sb.busy) begin
      send_beat(mk(esc_pkg::REQ_RESP, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                   1'b1, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))));
    end
    in_valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] cap, input logic [7:0] dev, input int fail_pct,
                           input bit exhaust);
    req_t r;
    int   n;
    cfg_we <= 1'b1;
    cfg_index <= esc_pkg::CFG_RETRY_LIMIT;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_index <= esc_pkg::CFG_DEVICE;
    cfg_wdata <= dev;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.retry_cap = cap;
    sb.device = dev;
    if (exhaust) begin
      // fail every attempt until the retry budget runs out
      r = mk(esc_pkg::REQ_WRITE, 9'd200, 8'($urandom_range(0, 255)), 1'b0, 8'h00, 4'h0);
      if (sb.valid_map[200]) r.wdata = ~sb.cached[200];
      send_beat(r);
      repeat (int'(cap) + 1) begin
        send_beat(mk(esc_pkg::REQ_RESP, 9'($urandom_range(0, 511)),
                     8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)),
                     4'($urandom_range(0, 15))));
      end
    end
    n = 0;
    while (n < PHASE_ITEMS) begin
      r = random_request(fail_pct);
      send_beat(r);
      if (r.kind != REQ_UNUSED) n++;
    end
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_address = '0;
    in_write_data = '0;
    in_bus_ok = 1'b0;
    in_bus_read_data = '0;
    in_bus_error_code = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(mk(esc_pkg::REQ_READ, 9'd0, 8'h00, 1'b0, 8'h00, 4'h0));
    send_beat(mk(esc_pkg::REQ_RESP, 9'd0, 8'h00, 1'b1, 8'hFF, 4'hF));
    send_beat(mk(esc_pkg::REQ_READ, 9'd0, 8'h00, 1'b0, 8'h00, 4'h0));
    send_beat(mk(esc_pkg::REQ_WRITE, 9'd0, 8'hFF, 1'b0, 8'h00, 4'h0));
    send_beat(mk(esc_pkg::REQ_WRITE, 9'd0, 8'h00, 1'b1, 8'hFF, 4'hF));
    send_beat(mk(esc_pkg::REQ_RESP, 9'h1FF, 8'hFF, 1'b0, 8'hFF, 4'hF));
    send_beat(mk(esc_pkg::REQ_RESP, 9'd0, 8'h00, 1'b1, 8'h5C, 4'h0));
    send_beat(mk(esc_pkg::REQ_READ, 9'd255, 8'hFF, 1'b1, 8'hFF, 4'hF));
    send_beat(mk(esc_pkg::REQ_RESP, 9'd0, 8'h00, 1'b1, 8'hA5, 4'h0));
    send_beat(mk(esc_pkg::REQ_READ, 9'd256, 8'h00, 1'b0, 8'h00, 4'h0));
    send_beat(mk(esc_pkg::REQ_READ, 9'd511, 8'h00, 1'b0, 8'h00, 4'h0));
    send_beat(mk(esc_pkg::REQ_WRITE, 9'd511, 8'hFF, 1'b1, 8'hFF, 4'hF));
    send_beat(mk(esc_pkg::REQ_RESP, 9'd3, 8'h00, 1'b1, 8'h77, 4'h1));
    send_beat(mk(esc_pkg::REQ_WRITE, 9'd128, 8'h5A, 1'b0, 8'h00, 4'h0));
    send_beat(mk(esc_pkg::REQ_READ, 9'd0, 8'h00, 1'b0, 8'h00, 4'h0));
    send_beat(mk(esc_pkg::REQ_WRITE, 9'd511, 8'hFF, 1'b0, 8'h00, 4'h0));
    send_beat(mk(REQ_UNUSED, 9'h1FF, 8'hFF, 1'b1, 8'hFF, 4'hF));
    send_beat(mk(esc_pkg::REQ_RESP, 9'd0, 8'h00, 1'b1, 8'h11, 4'h0));
    send_beat(mk(esc_pkg::REQ_READ, 9'd128, 8'h00, 1'b0, 8'h00, 4'h0));
    send_beat(mk(esc_pkg::REQ_READ, 9'd1, 8'h00, 1'b0, 8'h00, 4'h0));
    send_beat(mk(esc_pkg::REQ_RESP, 9'd0, 8'h00, 1'b0, 8'h00, 4'h0));
    send_beat(mk(esc_pkg::REQ_RESP, 9'd0, 8'h00, 1'b1, 8'h00, 4'h0));
    settle();

    run_phase(esc_pkg::RETRY_LIMIT_RST, esc_pkg::DEVICE_RST, 25, 1'b0);
    run_phase(8'd0, 8'd0, 40, 1'b0);
    run_phase(8'd255, 8'd255, 30, 1'b1);
    run_phase(8'd1, 8'($urandom_range(0, 255)), 50, 1'b0);
    run_phase(8'd3, 8'($urandom_range(0, 255)), 35, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 20, 1'b0);

    if (sb.mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/esc_pkg.sv
hw/rtl/eeprom_shadow_cache_with_retry.sv
sim/tb_eeprom_shadow_cache_with_retry.sv
